>>> src/bfsp_pkg.sv
// Shared types and constants for the bit field stream packer.
package bfsp_pkg;

   localparam int unsigned MaxFieldBits = 8;
   localparam int unsigned QueueDepth   = 4;
   localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

   typedef logic [7:0] byte_type;

   // One packed byte with its end-of-block mark.
   typedef struct packed {
      logic     eob;
      byte_type data;
   } out_entry_type;

   // What one component produces: up to two bytes and the next fill state.
   typedef struct packed {
      logic [1:0]    count;
      out_entry_type first;
      out_entry_type second;
      byte_type      partial_next;
      logic [2:0]    fill_next;
   } merge_result_type;

endpackage

>>> src/bfsp_merge.sv
// Shift-and-merge of one component into the partial byte.
module bfsp_merge
   import bfsp_pkg::*;
(
   input  byte_type         partial_byte,
   input  logic [2:0]       bit_fill,
   input  byte_type         value,
   input  logic [3:0]       width,
   input  logic             last,
   output merge_result_type result
);

   logic [3:0]  w_sat;
   logic [3:0]  room;
   logic [3:0]  k;
   logic [3:0]  rem;
   logic [3:0]  fill_sum;
   logic [8:0]  low_mask;
   logic [8:0]  rem_mask;
   logic [8:0]  low_bits;
   logic [8:0]  high_bits;
   logic [15:0] low_shifted;
   logic [15:0] high_shifted;
   byte_type    merged;
   byte_type    partial_new;
   logic [2:0]  fill_new;
   logic        complete;
   logic        flush;

   always_comb begin
      w_sat    = (width > 4'(MaxFieldBits)) ? 4'(MaxFieldBits) : width;
      room     = 4'd8 - {1'b0, bit_fill};
      k        = (w_sat < room) ? w_sat : room;
      rem      = w_sat - k;
      low_mask = (9'd1 << k) - 9'd1;
      rem_mask = (9'd1 << rem) - 9'd1;
      low_bits = {1'b0, value} & low_mask;
      high_bits = ({1'b0, value} >> k) & rem_mask;

      // low part lands just under the bits already filled
      low_shifted  = {7'd0, low_bits} << (room - k);
      high_shifted = {7'd0, high_bits} << (4'd8 - rem);
      merged       = partial_byte | low_shifted[7:0];
      fill_sum     = {1'b0, bit_fill} + k;
      complete     = fill_sum[3];

      if (complete) begin
         partial_new = (rem != 4'd0) ? high_shifted[7:0] : 8'd0;
         fill_new    = rem[2:0];
      end else begin
         partial_new = merged;
         fill_new    = fill_sum[2:0];
      end

      flush = last && (fill_new != 3'd0);

      result.count        = {1'b0, complete} + {1'b0, flush};
      result.first.data   = complete ? merged : partial_new;
      result.first.eob    = last && !(complete && flush);
      result.second.data  = partial_new;
      result.second.eob   = last;
      result.partial_next = last ? 8'd0 : partial_new;
      result.fill_next    = last ? 3'd0 : fill_new;
   end

endmodule

>>> src/bit_field_stream_packer_core.sv
// Top level: variable-width bit packer, components to MSB-first bytes.
// A request's bytes are registered into the result queue when it is accepted, behind any bytes still waiting there.
// Throughput: one request per cycle while req_tready is high; a request yields 0 to 2 bytes and the
// output drains one byte per cycle while rsp_tready is high through a 4-entry result queue, so
// sustained input rate is bounded by the byte rate of the rsp side.
// Reset clears the fill state and empties the result queue.
module bit_field_stream_packer_core
   import bfsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] value, [11:8] width, [15:12] zero
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] out_byte
   output logic        rsp_tlast   // end_of_block
);

   byte_type                partial_ff, partial_in;
   logic [2:0]              fill_ff, fill_in;
   out_entry_type           queue_ff [QueueDepth];
   logic [QueuePtrBits-1:0] head_ff, head_in;
   logic [QueuePtrBits-1:0] tail_ff, tail_in;
   logic [QueuePtrBits:0]   count_ff, count_in;
   merge_result_type        merge;
   logic                    req_fire;
   logic                    rsp_fire;
   out_entry_type           head_entry;

   bfsp_merge u_merge (
      .partial_byte (partial_ff),
      .bit_fill     (fill_ff),
      .value        (req_tdata[7:0]),
      .width        (req_tdata[11:8]),
      .last         (req_tlast),
      .result       (merge)
   );

   // room for the worst case of two bytes
   assign req_tready = (count_ff <= (QueuePtrBits+1)'(QueueDepth - 2));
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign head_entry = queue_ff[head_ff];
   assign rsp_tdata  = head_entry.data;
   assign rsp_tlast  = head_entry.eob;

   always_comb begin
      partial_in = partial_ff;
      fill_in    = fill_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      if (req_fire) begin
         partial_in = merge.partial_next;
         fill_in    = merge.fill_next;
         tail_in    = tail_ff + QueuePtrBits'(merge.count);
         count_in   = count_in + (QueuePtrBits+1)'(merge.count);
      end
      if (rsp_fire) begin
         head_in  = head_ff + QueuePtrBits'(1);
         count_in = count_in - (QueuePtrBits+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         fill_ff    <= '0;
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
      end else begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (merge.count != 2'd0)) begin
         queue_ff[tail_ff] <= merge.first;
      end
      if (req_fire && (merge.count == 2'd2)) begin
         queue_ff[tail_ff + QueuePtrBits'(1)] <= merge.second;
      end
   end

endmodule
